// ===== rtl/core/ladder_keypad_debouncer_defines.svh =====
// Assertion macros for the keypad debouncer checker.
`ifndef LADDER_KEYPAD_DEBOUNCER_DEFINES_SVH
`define LADDER_KEYPAD_DEBOUNCER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define LKD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define LKD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lkd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lkd_pkg;

  localparam int LADDER1_KEYS = 4;
  localparam int LADDER2_KEYS = 2;

  localparam int KEY_W        = 7;
  localparam int LADDER2_BASE = 4;
  localparam int POWER_BIT    = 6;
  localparam int LEVEL_W      = 12;
  localparam int DEBOUNCE_W   = 16;
  localparam int TIME_W       = 32;

  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NO_BUTTON_LEVEL = 3'd0,
    CFG_LADDER1_LIMIT_A = 3'd1,
    CFG_LADDER1_LIMIT_B = 3'd2,
    CFG_LADDER1_LIMIT_C = 3'd3,
    CFG_LADDER2_LIMIT_A = 3'd4,
    CFG_DEBOUNCE_MS     = 3'd5
  } cfg_idx_t;

  localparam logic [LEVEL_W-1:0]    RST_NO_BUTTON_LEVEL = 12'd3800;
  localparam logic [LEVEL_W-1:0]    RST_LADDER1_LIMIT_A = 12'd3100;
  localparam logic [LEVEL_W-1:0]    RST_LADDER1_LIMIT_B = 12'd2090;
  localparam logic [LEVEL_W-1:0]    RST_LADDER1_LIMIT_C = 12'd750;
  localparam logic [LEVEL_W-1:0]    RST_LADDER2_LIMIT_A = 12'd1120;
  localparam logic [DEBOUNCE_W-1:0] RST_DEBOUNCE_MS     = 16'd5;

  typedef struct packed {
    logic [LEVEL_W-1:0]    no_button_level;
    logic [LEVEL_W-1:0]    ladder1_limit_a;
    logic [LEVEL_W-1:0]    ladder1_limit_b;
    logic [LEVEL_W-1:0]    ladder1_limit_c;
    logic [LEVEL_W-1:0]    ladder2_limit_a;
    logic [DEBOUNCE_W-1:0] debounce_ms;
  } lkd_cfg_t;

  // One classified poll waiting for the debounce stage.
  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    logic [KEY_W-1:0]  raw;
  } lkd_item_t;

  // Queue handshake between front and back.
  typedef struct packed {
    logic valid;
    logic full;
  } lkd_qstat_t;

endpackage

`default_nettype wire

// ===== rtl/core/lkd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lkd_front import lkd_pkg::*; (
  input  lkd_cfg_t           cfg,
  input  logic [TIME_W-1:0]  time_ms,
  input  logic [LEVEL_W-1:0] ladder1_level,
  input  logic [LEVEL_W-1:0] ladder2_level,
  input  logic               power_key_low,
  output lkd_item_t          item
);

  logic [LEVEL_W-1:0]      b1 [0:3];
  logic [LEVEL_W-1:0]      b2 [0:1];
  logic [LADDER1_KEYS-1:0] hit1;
  logic [LADDER2_KEYS-1:0] hit2;
  logic [KEY_W-1:0]        raw;
  logic                    found1;
  logic                    found2;

  always_comb begin
    b1[0] = cfg.no_button_level;
    b1[1] = cfg.ladder1_limit_a;
    b1[2] = cfg.ladder1_limit_b;
    b1[3] = cfg.ladder1_limit_c;
    b2[0] = cfg.no_button_level;
    b2[1] = cfg.ladder2_limit_a;
  end

  // Range match per key; last key of a ladder has no floor.
  always_comb begin
    for (int i = 0; i < LADDER1_KEYS; i++) begin
      hit1[i] = (ladder1_level <= b1[i]);
    end
    for (int i = 0; i < LADDER1_KEYS - 1; i++) begin
      hit1[i] = hit1[i] && (ladder1_level > b1[i+1]);
    end
    for (int i = 0; i < LADDER2_KEYS; i++) begin
      hit2[i] = (ladder2_level <= b2[i]);
    end
    for (int i = 0; i < LADDER2_KEYS - 1; i++) begin
      hit2[i] = hit2[i] && (ladder2_level > b2[i+1]);
    end
  end

  // Lowest matching key wins on each ladder.
  always_comb begin
    raw    = '0;
    found1 = 1'b0;
    found2 = 1'b0;
    for (int i = 0; i < LADDER1_KEYS; i++) begin
      if (hit1[i] && !found1) begin
        raw[i] = 1'b1;
        found1 = 1'b1;
      end
    end
    for (int i = 0; i < LADDER2_KEYS; i++) begin
      if (hit2[i] && !found2) begin
        raw[LADDER2_BASE + i] = 1'b1;
        found2 = 1'b1;
      end
    end
    raw[POWER_BIT] = ~power_key_low;
  end

  assign item.time_ms = time_ms;
  assign item.raw     = raw;

endmodule

`default_nettype wire

// ===== rtl/core/lkd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lkd_queue import lkd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  lkd_item_t  wr_item,
  input  logic       pop,
  output lkd_item_t  rd_item,
  output lkd_qstat_t stat
);

  lkd_item_t          mem [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign stat.valid = (count != '0);
  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;
  assign rd_item    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lkd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lkd_back import lkd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  lkd_cfg_t          cfg,
  input  lkd_item_t         item,
  input  logic              item_valid,
  output logic              item_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KEY_W-1:0]  stable_keys,
  output logic [KEY_W-1:0]  pressed_keys,
  output logic [KEY_W-1:0]  released_keys,
  output logic [TIME_W-1:0] held_ms
);

  logic [KEY_W-1:0]  last_raw;
  logic [KEY_W-1:0]  stable_vector;
  logic [TIME_W-1:0] change_time;
  logic [TIME_W-1:0] press_start_time;
  logic [TIME_W-1:0] press_finish_time;

  logic [KEY_W-1:0]  last_raw_next;
  logic [KEY_W-1:0]  stable_vector_next;
  logic [TIME_W-1:0] change_time_next;
  logic [TIME_W-1:0] press_start_time_next;
  logic [TIME_W-1:0] press_finish_time_next;
  logic [KEY_W-1:0]  pressed;
  logic [KEY_W-1:0]  released;
  logic [TIME_W-1:0] held;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] d_now_start;
  logic [TIME_W-1:0] d_fin_start;
  logic              fire;
  logic              start_upd;
  logic              finish_upd;

  assign item_pop = item_valid && (!out_valid || !out_stall);

  always_comb begin
    last_raw_next    = last_raw;
    change_time_next = change_time;
    if (item.raw != last_raw) begin
      last_raw_next    = item.raw;
      change_time_next = item.time_ms;
    end
    elapsed = item.time_ms - change_time_next;
    fire    = (elapsed > TIME_W'(cfg.debounce_ms)) && (item.raw != stable_vector);

    pressed  = fire ? (item.raw & ~stable_vector) : '0;
    released = fire ? (stable_vector & ~item.raw) : '0;
    stable_vector_next = fire ? item.raw : stable_vector;

    start_upd  = (pressed != '0) && (stable_vector == '0);
    finish_upd = (released != '0) && (item.raw == '0);
    press_start_time_next  = start_upd ? item.time_ms : press_start_time;
    press_finish_time_next = finish_upd ? item.time_ms : press_finish_time;

    // Both differences built from old state so they run beside the compare.
    d_now_start = item.time_ms - press_start_time;
    d_fin_start = press_finish_time - press_start_time;
    if (stable_vector_next != '0) begin
      held = start_upd ? '0 : d_now_start;
    end else begin
      held = finish_upd ? d_now_start : d_fin_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw          <= '0;
      stable_vector     <= '0;
      change_time       <= '0;
      press_start_time  <= '0;
      press_finish_time <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (item_pop) begin
        last_raw          <= last_raw_next;
        stable_vector     <= stable_vector_next;
        change_time       <= change_time_next;
        press_start_time  <= press_start_time_next;
        press_finish_time <= press_finish_time_next;
        out_valid         <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      stable_keys   <= stable_vector_next;
      pressed_keys  <= pressed;
      released_keys <= released;
      held_ms       <= held;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ladder_keypad_debouncer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Resistor-ladder keypad debouncer. Every input beat is one poll (time, two
// ladder ADC levels, active-low power pin); every poll yields exactly one
// output beat with the debounced key vector, the keys pressed and released
// on that poll, and the held time. One poll per clock is sustained while
// out_stall is low. The front decodes the ladders as the beat arrives and
// drops it into a two-entry queue; the back holds the debounce state and an
// output register, so input is still taken while a result waits under
// out_stall until the queue fills. Configuration writes are always ready
// and must only be issued while the block is idle; unknown register indexes
// are ignored.
module ladder_keypad_debouncer import lkd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TIME_W-1:0]     time_ms,
  input  logic [LEVEL_W-1:0]    ladder1_level,
  input  logic [LEVEL_W-1:0]    ladder2_level,
  input  logic                  power_key_low,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [KEY_W-1:0]      stable_keys,
  output logic [KEY_W-1:0]      pressed_keys,
  output logic [KEY_W-1:0]      released_keys,
  output logic [TIME_W-1:0]     held_ms
);

  lkd_cfg_t   cfg;
  lkd_item_t  front_item;
  lkd_item_t  head_item;
  lkd_qstat_t qstat;
  logic       pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.no_button_level <= RST_NO_BUTTON_LEVEL;
      cfg.ladder1_limit_a <= RST_LADDER1_LIMIT_A;
      cfg.ladder1_limit_b <= RST_LADDER1_LIMIT_B;
      cfg.ladder1_limit_c <= RST_LADDER1_LIMIT_C;
      cfg.ladder2_limit_a <= RST_LADDER2_LIMIT_A;
      cfg.debounce_ms     <= RST_DEBOUNCE_MS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NO_BUTTON_LEVEL: cfg.no_button_level <= cfg_data[LEVEL_W-1:0];
        CFG_LADDER1_LIMIT_A: cfg.ladder1_limit_a <= cfg_data[LEVEL_W-1:0];
        CFG_LADDER1_LIMIT_B: cfg.ladder1_limit_b <= cfg_data[LEVEL_W-1:0];
        CFG_LADDER1_LIMIT_C: cfg.ladder1_limit_c <= cfg_data[LEVEL_W-1:0];
        CFG_LADDER2_LIMIT_A: cfg.ladder2_limit_a <= cfg_data[LEVEL_W-1:0];
        CFG_DEBOUNCE_MS:     cfg.debounce_ms     <= cfg_data[DEBOUNCE_W-1:0];
        default: ;
      endcase
    end
  end

  lkd_front u_front (
    .cfg           (cfg),
    .time_ms       (time_ms),
    .ladder1_level (ladder1_level),
    .ladder2_level (ladder2_level),
    .power_key_low (power_key_low),
    .item          (front_item)
  );

  assign in_stall = qstat.full;

  lkd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (in_valid),
    .wr_item (front_item),
    .pop     (pop),
    .rd_item (head_item),
    .stat    (qstat)
  );

  lkd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .item          (head_item),
    .item_valid    (qstat.valid),
    .item_pop      (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .stable_keys   (stable_keys),
    .pressed_keys  (pressed_keys),
    .released_keys (released_keys),
    .held_ms       (held_ms)
  );

endmodule

`default_nettype wire

// ===== rtl/core/lkd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "ladder_keypad_debouncer_defines.svh"

module lkd_checker import lkd_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [KEY_W-1:0]      stable_keys,
  input logic [KEY_W-1:0]      pressed_keys,
  input logic [KEY_W-1:0]      released_keys,
  input logic [TIME_W-1:0]     held_ms
);

  // Stalled result beat must not move.
  `LKD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(stable_keys) && $stable(pressed_keys) && $stable(released_keys) && $stable(held_ms), "result beat changed under stall")

  `LKD_ASSERT_NOW(a_edges_disjoint, out_valid, (pressed_keys & released_keys) == '0, "key both pressed and released")

  `LKD_ASSERT_NOW(a_pressed_in_stable, out_valid, ((pressed_keys & ~stable_keys) | (released_keys & stable_keys)) == '0, "edge bits disagree with stable vector")

  // A ladder can show at most one key at a time.
  `LKD_ASSERT_NOW(a_ladder_onehot, out_valid, $onehot0(stable_keys[LADDER2_BASE-1:0]) && $onehot0(stable_keys[POWER_BIT-1:LADDER2_BASE]), "two keys of one ladder stable")

endmodule

bind ladder_keypad_debouncer lkd_checker u_lkd_checker (.*);

`default_nettype wire

// ===== dv/keypad_result_checker.sv =====
`timescale 1ns / 1ps

module keypad_result_checker
  import lkd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [TIME_W-1:0]     time_ms,
  input  logic [LEVEL_W-1:0]    ladder1_level,
  input  logic [LEVEL_W-1:0]    ladder2_level,
  input  logic                  power_key_low,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [KEY_W-1:0]      stable_keys,
  input  logic [KEY_W-1:0]      pressed_keys,
  input  logic [KEY_W-1:0]      released_keys,
  input  logic [TIME_W-1:0]     held_ms,
  output int                    mismatch_count,
  output int                    pending_results
);

  typedef struct packed {
    logic [KEY_W-1:0]  stable;
    logic [KEY_W-1:0]  pressed;
    logic [KEY_W-1:0]  released;
    logic [TIME_W-1:0] held;
  } keypad_result_t;

  keypad_result_t expected_results[$];
  int errors = 0;

  lkd_cfg_t          cfg_shadow;
  logic [KEY_W-1:0]  prev_raw;
  logic [KEY_W-1:0]  debounced;
  logic [TIME_W-1:0] change_stamp;
  logic [TIME_W-1:0] press_begin;
  logic [TIME_W-1:0] press_end;

  assign mismatch_count  = errors;
  assign pending_results = expected_results.size();

  // First key whose range holds the level wins; nkeys means no key.
  function automatic int ladder_key(input logic [LEVEL_W-1:0] level,
                                    input logic [LADDER1_KEYS-1:0][LEVEL_W-1:0] bounds,
                                    input int nkeys);
    for (int i = 0; i < nkeys; i++) begin
      if (level <= bounds[i]) begin
        if (i + 1 >= nkeys) return i;
        else if (level > bounds[i+1]) return i;
      end
    end
    return nkeys;
  endfunction

  function automatic keypad_result_t debounce_poll(input logic [TIME_W-1:0] now,
                                                   input logic [LEVEL_W-1:0] lvl1,
                                                   input logic [LEVEL_W-1:0] lvl2,
                                                   input logic pwr_low);
    logic [LADDER1_KEYS-1:0][LEVEL_W-1:0] bounds1;
    logic [LADDER1_KEYS-1:0][LEVEL_W-1:0] bounds2;
    logic [KEY_W-1:0]  raw;
    logic [TIME_W-1:0] elapsed;
    int k;
    keypad_result_t r;
    bounds1 = {cfg_shadow.ladder1_limit_c, cfg_shadow.ladder1_limit_b,
               cfg_shadow.ladder1_limit_a, cfg_shadow.no_button_level};
    bounds2 = {{(2*LEVEL_W){1'b0}}, cfg_shadow.ladder2_limit_a, cfg_shadow.no_button_level};
    raw = '0;
    k = ladder_key(lvl1, bounds1, LADDER1_KEYS);
    if (k < LADDER1_KEYS) raw[k] = 1'b1;
    k = ladder_key(lvl2, bounds2, LADDER2_KEYS);
    if (k < LADDER2_KEYS) raw[LADDER2_BASE + k] = 1'b1;
    if (!pwr_low) raw[POWER_BIT] = 1'b1;

    r.pressed  = '0;
    r.released = '0;
    if (raw != prev_raw) begin
      change_stamp = now;
      prev_raw     = raw;
    end
    elapsed = now - change_stamp;
    if (elapsed > TIME_W'(cfg_shadow.debounce_ms) && raw != debounced) begin
      r.pressed  = raw & ~debounced;
      r.released = debounced & ~raw;
      if (r.pressed != '0 && debounced == '0) press_begin = now;
      if (r.released != '0 && raw == '0) press_end = now;
      debounced = raw;
    end
    r.stable = debounced;
    r.held   = (debounced != '0) ? now - press_begin : press_end - press_begin;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    keypad_result_t want;
    if (rst) begin
      cfg_shadow   <= '{RST_NO_BUTTON_LEVEL, RST_LADDER1_LIMIT_A, RST_LADDER1_LIMIT_B,
                        RST_LADDER1_LIMIT_C, RST_LADDER2_LIMIT_A, RST_DEBOUNCE_MS};
      prev_raw     = '0;
      debounced    = '0;
      change_stamp = '0;
      press_begin  = '0;
      press_end    = '0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NO_BUTTON_LEVEL: cfg_shadow.no_button_level <= cfg_data[LEVEL_W-1:0];
          CFG_LADDER1_LIMIT_A: cfg_shadow.ladder1_limit_a <= cfg_data[LEVEL_W-1:0];
          CFG_LADDER1_LIMIT_B: cfg_shadow.ladder1_limit_b <= cfg_data[LEVEL_W-1:0];
          CFG_LADDER1_LIMIT_C: cfg_shadow.ladder1_limit_c <= cfg_data[LEVEL_W-1:0];
          CFG_LADDER2_LIMIT_A: cfg_shadow.ladder2_limit_a <= cfg_data[LEVEL_W-1:0];
          CFG_DEBOUNCE_MS:     cfg_shadow.debounce_ms     <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none, actual %0h/%0h/%0h/%0h",
                   $time, stable_keys, pressed_keys, released_keys, held_ms);
        end else begin
          want = expected_results.pop_front();
          check_field("stable_keys", TIME_W'(want.stable), TIME_W'(stable_keys));
          check_field("pressed_keys", TIME_W'(want.pressed), TIME_W'(pressed_keys));
          check_field("released_keys", TIME_W'(want.released), TIME_W'(released_keys));
          check_field("held_ms", want.held, held_ms);
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(debounce_poll(time_ms, ladder1_level, ladder2_level,
                                                 power_key_low));
    end
  end

endmodule

// ===== dv/tb_ladder_keypad_debouncer.sv =====
`timescale 1ns / 1ps

module tb_ladder_keypad_debouncer;
  import lkd_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int POLLS_PER_PHASE = 125;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [TIME_W-1:0]     time_ms = '0;
  logic [LEVEL_W-1:0]    ladder1_level = '1;
  logic [LEVEL_W-1:0]    ladder2_level = '1;
  logic                  power_key_low = 1'b1;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [KEY_W-1:0]      stable_keys;
  logic [KEY_W-1:0]      pressed_keys;
  logic [KEY_W-1:0]      released_keys;
  logic [TIME_W-1:0]     held_ms;
  int                    mismatch_count;
  int                    pending_results;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;

  // Local copy of the ladder bounds and delay, used to aim levels and time steps.
  logic [4:0][LEVEL_W-1:0] bounds_now = {RST_LADDER2_LIMIT_A, RST_LADDER1_LIMIT_C,
                                         RST_LADDER1_LIMIT_B, RST_LADDER1_LIMIT_A,
                                         RST_NO_BUTTON_LEVEL};
  logic [DEBOUNCE_W-1:0]   cur_debounce = RST_DEBOUNCE_MS;
  logic [TIME_W-1:0]       now_ms = '0;

  ladder_keypad_debouncer u_top (.*);

  keypad_result_checker u_checker (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_NO_BUTTON_LEVEL: bounds_now[0] = data[LEVEL_W-1:0];
      CFG_LADDER1_LIMIT_A: bounds_now[1] = data[LEVEL_W-1:0];
      CFG_LADDER1_LIMIT_B: bounds_now[2] = data[LEVEL_W-1:0];
      CFG_LADDER1_LIMIT_C: bounds_now[3] = data[LEVEL_W-1:0];
      CFG_LADDER2_LIMIT_A: bounds_now[4] = data[LEVEL_W-1:0];
      CFG_DEBOUNCE_MS:     cur_debounce  = data;
      default: ;
    endcase
  endtask

  task automatic send_poll(input logic [TIME_W-1:0] t, input logic [LEVEL_W-1:0] l1,
                           input logic [LEVEL_W-1:0] l2, input logic pwr);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    time_ms       <= t;
    ladder1_level <= l1;
    ladder2_level <= l2;
    power_key_low <= pwr;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  // Levels on or next to a range bound as often as random ones, sometimes the rails.
  function automatic logic [LEVEL_W-1:0] pick_level();
    logic [LEVEL_W-1:0] anchor;
    anchor = bounds_now[$urandom_range(4)];
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return anchor;
      4:       return anchor + 1'b1;
      5:       return anchor - 1'b1;
      default: return LEVEL_W'($urandom);
    endcase
  endfunction

  // Held key patterns with bounce, plus a share of pure noise segments.
  task automatic run_random(input int n);
    int sent;
    int seg_len;
    int r;
    logic [LEVEL_W-1:0] l1;
    logic [LEVEL_W-1:0] l2;
    logic pwr;
    logic noisy;
    logic [TIME_W-1:0] step;
    sent = 0;
    while (sent < n) begin
      seg_len = $urandom_range(1, 12);
      l1 = pick_level();
      l2 = pick_level();
      pwr = 1'($urandom_range(1));
      noisy = ($urandom_range(9) == 0);
      for (int k = 0; k < seg_len && sent < n; k++) begin
        r = $urandom_range(99);
        if (r < 70) step = $urandom_range(3);
        else if (r < 90) step = TIME_W'(cur_debounce) + $urandom_range(2) - 1;
        else if (r < 97) step = $urandom_range(2 * cur_debounce + 8);
        else step = $urandom;
        now_ms += step;
        if (noisy || $urandom_range(99) < 6)
          send_poll(now_ms, LEVEL_W'($urandom), LEVEL_W'($urandom), 1'($urandom));
        else
          send_poll(now_ms, l1, l2, pwr);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // reset settings: bounds hit exactly, debounce edge, wrap and backwards time
    send_poll(32'd0,  12'd4095, 12'd4095, 1'b1);
    send_poll(32'd10, 12'd3800, 12'd4095, 1'b1);
    send_poll(32'd15, 12'd3800, 12'd4095, 1'b1);
    send_poll(32'd16, 12'd3800, 12'd4095, 1'b1);
    send_poll(32'd20, 12'd3100, 12'd1120, 1'b0);
    send_poll(32'd30, 12'd3100, 12'd1120, 1'b0);
    send_poll(32'd31, 12'd2090, 12'd1121, 1'b0);
    send_poll(32'd40, 12'd2090, 12'd1121, 1'b0);
    send_poll(32'd41, 12'd0,    12'd0,    1'b1);
    send_poll(32'd50, 12'd0,    12'd0,    1'b1);
    send_poll(32'd51, 12'd750,  12'd3801, 1'b1);
    send_poll(32'd60, 12'd751,  12'd3800, 1'b1);
    send_poll(32'd70, 12'd751,  12'd3800, 1'b1);
    send_poll(32'd71, 12'd3801, 12'd3801, 1'b1);
    send_poll(32'd80, 12'd3801, 12'd3801, 1'b1);
    send_poll(32'hFFFF_FFFE, 12'd3101, 12'd4095, 1'b1);
    send_poll(32'h0000_0005, 12'd3101, 12'd4095, 1'b1);
    send_poll(32'd2,  12'd4095, 12'd4095, 1'b1);
    send_poll(32'd1,  12'd4095, 12'd4095, 1'b1);
    send_poll(32'hFFFF_FFFF, 12'd0, 12'd0, 1'b0);
    send_poll(32'hFFFF_FFFF, 12'd0, 12'd0, 1'b0);
    now_ms = 32'hFFFF_FFFF;

    hold_req++;
    run_random(POLLS_PER_PHASE);
    drain();

    // extremes, zero delay, upper bits of level writes dropped
    write_reg(CFG_NO_BUTTON_LEVEL, 16'hFFFF);
    write_reg(CFG_LADDER1_LIMIT_A, 16'hFFFF);
    write_reg(CFG_LADDER1_LIMIT_B, 16'h0000);
    write_reg(CFG_LADDER1_LIMIT_C, 16'hF000);
    write_reg(CFG_LADDER2_LIMIT_A, 16'h0000);
    write_reg(CFG_DEBOUNCE_MS,     16'h0000);
    write_reg(CFG_SPARE_6,         16'h1234);
    write_reg(CFG_SPARE_7,         16'hFFFF);
    send_idle_pct = 60;
    stall_pct = 0;
    run_random(POLLS_PER_PHASE);
    drain();

    // random, usually unordered bounds
    write_reg(CFG_NO_BUTTON_LEVEL, 16'($urandom_range(2000, 4095)));
    write_reg(CFG_LADDER1_LIMIT_A, 16'($urandom));
    write_reg(CFG_LADDER1_LIMIT_B, 16'($urandom));
    write_reg(CFG_LADDER1_LIMIT_C, 16'($urandom));
    write_reg(CFG_LADDER2_LIMIT_A, 16'($urandom));
    write_reg(CFG_DEBOUNCE_MS,     16'($urandom_range(20)));
    send_idle_pct = 0;
    stall_pct = 60;
    run_random(POLLS_PER_PHASE);
    drain();

    // out of order bounds and the longest delay
    write_reg(CFG_NO_BUTTON_LEVEL, 16'd3000);
    write_reg(CFG_LADDER1_LIMIT_A, 16'd100);
    write_reg(CFG_LADDER1_LIMIT_B, 16'd3500);
    write_reg(CFG_LADDER1_LIMIT_C, 16'd4095);
    write_reg(CFG_LADDER2_LIMIT_A, 16'd4095);
    write_reg(CFG_DEBOUNCE_MS,     16'hFFFF);
    send_idle_pct = 12;
    stall_pct = 12;
    run_random(POLLS_PER_PHASE);
    drain();

    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
